/* design/dosp_pkg.sv */
// Shared constants, codes and controller/datapath types for the depth order shaker pass.
package dosp_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int COORD_BITS  = 16;
  localparam int SLOT_W      = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
  localparam int DIST_W      = 2 * COORD_BITS + 2;
  localparam int IDX_W       = 6;
  localparam int POS_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CMD_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJECT_COUNT = 2'd0,
    CFG_EYE_X        = 2'd1,
    CFG_EYE_Y        = 2'd2,
    CFG_EYE_Z        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    SLOT_HOLD  = 2'd0,
    SLOT_CLEAR = 2'd1,
    SLOT_STEP  = 2'd2,
    SLOT_TURN  = 2'd3
  } slot_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRITE,
    S_READ_ADDR,
    S_READ_DATA,
    S_PASS_START,
    S_ORD_RD,
    S_ORD_WAIT,
    S_POS_RD,
    S_D0,
    S_D1,
    S_D2,
    S_D3,
    S_D4,
    S_TAKE,
    S_CMP,
    S_FWD_END,
    S_BWD_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     latch_item;
    logic     pos_we;
    logic     ord_rd_item;
    logic     res_load;
    slot_op_t slot_op;
    logic     cand_load;
    logic     abs_en;
    axis_t    axis;
    logic     sq_en;
    logic     acc_load;
    logic     acc_add;
    logic     take;
    logic     cmp_step;
    logic     end_write;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic short_pass;
    logic slot_last;
    logic slot_zero;
    logic bwd;
  } dp_status_t;

endpackage

/* design/dosp_in_if.sv */
// Input channel: one command beat with its position payload.
interface dosp_in_if;
  import dosp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] index;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;

  modport source (output valid, cmd, index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, cmd, index, pos_x, pos_y, pos_z, output ready);
  modport monitor (input valid, ready, cmd, index, pos_x, pos_y, pos_z);
endinterface

/* design/dosp_out_if.sv */
// Output channel: one result beat carrying an order entry.
interface dosp_out_if;
  import dosp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] order_entry;

  modport source (output valid, order_entry, input ready);
  modport sink (input valid, order_entry, output ready);
  modport monitor (input valid, ready, order_entry);
endinterface

/* design/dosp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dosp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

/* design/dosp_ctrl.sv */
// Sequencing state machine for write, read and shaker pass commands.
module dosp_ctrl import dosp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [CMD_W-1:0] item_cmd,
  output logic             item_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (item_cmd)
            CMD_WRITE: state_next = S_WRITE;
            CMD_PASS:  state_next = S_PASS_START;
            CMD_READ:  state_next = S_READ_ADDR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_WRITE:      state_next = S_DONE;
      S_READ_ADDR:  state_next = S_READ_DATA;
      S_READ_DATA:  state_next = S_DONE;
      S_PASS_START: state_next = status.short_pass ? S_DONE : S_ORD_RD;
      S_ORD_RD:     state_next = S_ORD_WAIT;
      S_ORD_WAIT:   state_next = S_POS_RD;
      S_POS_RD:     state_next = S_D0;
      S_D0:         state_next = S_D1;
      S_D1:         state_next = S_D2;
      S_D2:         state_next = S_D3;
      S_D3:         state_next = S_D4;
      S_D4:         state_next = (!status.bwd && status.slot_zero) ? S_TAKE : S_CMP;
      S_TAKE:       state_next = S_ORD_RD;
      S_CMP: begin
        if (!status.bwd && status.slot_last) begin
          state_next = S_FWD_END;
        end else if (status.bwd && status.slot_zero) begin
          state_next = S_BWD_END;
        end else begin
          state_next = S_ORD_RD;
        end
      end
      S_FWD_END:    state_next = S_ORD_RD;
      S_BWD_END:    state_next = S_DONE;
      S_DONE:       state_next = out_free ? S_IDLE : S_DONE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.axis   = AXIS_X;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready     = 1'b1;
        cmd.latch_item = item_valid;
      end
      S_WRITE:      cmd.pos_we = 1'b1;
      S_READ_ADDR:  cmd.ord_rd_item = 1'b1;
      S_READ_DATA: begin
        cmd.ord_rd_item = 1'b1;
        cmd.res_load    = 1'b1;
      end
      S_PASS_START: cmd.slot_op = SLOT_CLEAR;
      S_ORD_WAIT:   cmd.cand_load = 1'b1;
      S_D0: begin
        cmd.abs_en = 1'b1;
        cmd.axis   = AXIS_X;
      end
      S_D1: begin
        cmd.sq_en  = 1'b1;
        cmd.abs_en = 1'b1;
        cmd.axis   = AXIS_Y;
      end
      S_D2: begin
        cmd.acc_load = 1'b1;
        cmd.sq_en    = 1'b1;
        cmd.abs_en   = 1'b1;
        cmd.axis     = AXIS_Z;
      end
      S_D3: begin
        cmd.acc_add = 1'b1;
        cmd.sq_en   = 1'b1;
      end
      S_D4:         cmd.acc_add = 1'b1;
      S_TAKE: begin
        cmd.take    = 1'b1;
        cmd.slot_op = SLOT_STEP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if ((!status.bwd && status.slot_last) || (status.bwd && status.slot_zero)) begin
          cmd.slot_op = SLOT_HOLD;
        end else begin
          cmd.slot_op = SLOT_STEP;
        end
      end
      S_FWD_END: begin
        cmd.end_write = 1'b1;
        cmd.slot_op   = SLOT_TURN;
      end
      S_BWD_END:    cmd.end_write = 1'b1;
      S_DONE:       cmd.out_load = out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

/* design/dosp_datapath.sv */
// Position and order stores, distance unit, compare-and-carry logic and result register.
module dosp_datapath import dosp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [IDX_W-1:0]     item_index,
  input  logic [POS_W-1:0]     item_pos_x,
  input  logic [POS_W-1:0]     item_pos_y,
  input  logic [POS_W-1:0]     item_pos_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [IDX_W-1:0]     order_entry
);

  logic [CNT_W-1:0]      object_count;
  logic [COORD_BITS-1:0] eye_x;
  logic [COORD_BITS-1:0] eye_y;
  logic [COORD_BITS-1:0] eye_z;

  logic [IDX_W-1:0]      idx_q;
  logic [COORD_BITS-1:0] wr_x;
  logic [COORD_BITS-1:0] wr_y;
  logic [COORD_BITS-1:0] wr_z;

  logic [SLOT_W-1:0]     slot;
  logic                  bwd;
  logic [SLOT_W-1:0]     cand;
  logic [SLOT_W-1:0]     carry;
  logic [DIST_W-1:0]     carry_dist;
  logic [COORD_BITS-1:0] abs_q;
  logic [2*COORD_BITS-1:0] sq_q;
  logic [DIST_W-1:0]     acc;
  logic [IDX_W-1:0]      res;

  logic [MAX_OBJECTS-1:0] ord_valid;
  logic                  ord_vld_q;
  logic [SLOT_W-1:0]     ord_addr_q;
  logic [SLOT_W-1:0]     ord_ra;
  logic [SLOT_W-1:0]     ord_rd;
  logic [SLOT_W-1:0]     ord_val;
  logic                  sort_we;
  logic [SLOT_W-1:0]     sort_wa;
  logic [SLOT_W-1:0]     sort_wd;

  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_z;

  logic [CNT_W-1:0]      n_sat;
  logic [SLOT_W-1:0]     last_slot;
  logic                  swap;

  logic [COORD_BITS-1:0] eye_sel;
  logic [COORD_BITS-1:0] pos_sel;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]   mag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= '0;
      eye_x        <= '0;
      eye_y        <= '0;
      eye_z        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBJECT_COUNT: object_count <= cfg_data[CNT_W-1:0];
        CFG_EYE_X:        eye_x <= cfg_data[COORD_BITS-1:0];
        CFG_EYE_Y:        eye_y <= cfg_data[COORD_BITS-1:0];
        CFG_EYE_Z:        eye_z <= cfg_data[COORD_BITS-1:0];
        default:          eye_z <= eye_z;
      endcase
    end
  end

  assign n_sat = (object_count > CNT_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) : object_count;
  assign last_slot = SLOT_W'(n_sat - 1'b1);

  assign status.short_pass = n_sat < CNT_W'(2);
  assign status.slot_last  = slot == last_slot;
  assign status.slot_zero  = slot == '0;
  assign status.bwd        = bwd;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      idx_q <= item_index;
      wr_x  <= item_pos_x[COORD_BITS-1:0];
      wr_y  <= item_pos_y[COORD_BITS-1:0];
      wr_z  <= item_pos_z[COORD_BITS-1:0];
    end
  end

  dosp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBJECTS)) u_pos_x (
    .clk(clk), .we(cmd.pos_we), .wa(SLOT_W'(idx_q)), .wd(wr_x), .ra(cand), .rd(pos_x)
  );
  dosp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBJECTS)) u_pos_y (
    .clk(clk), .we(cmd.pos_we), .wa(SLOT_W'(idx_q)), .wd(wr_y), .ra(cand), .rd(pos_y)
  );
  dosp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBJECTS)) u_pos_z (
    .clk(clk), .we(cmd.pos_we), .wa(SLOT_W'(idx_q)), .wd(wr_z), .ra(cand), .rd(pos_z)
  );

  // Order store: an entry that was never written still holds its own slot number.
  assign ord_ra  = cmd.ord_rd_item ? SLOT_W'(idx_q) : slot;
  assign ord_val = ord_vld_q ? ord_rd : ord_addr_q;

  dosp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_OBJECTS)) u_order (
    .clk(clk), .we(sort_we), .wa(sort_wa), .wd(sort_wd), .ra(ord_ra), .rd(ord_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_valid <= '0;
    end else if (sort_we) begin
      ord_valid[sort_wa] <= 1'b1;
    end
    ord_vld_q  <= ord_valid[ord_ra];
    ord_addr_q <= ord_ra;
  end

  // The carried object is the one still moving in the sweep direction.
  assign swap    = bwd ? (acc > carry_dist) : (carry_dist > acc);
  assign sort_we = cmd.cmp_step || cmd.end_write;
  always_comb begin
    if (cmd.end_write) begin
      sort_wa = slot;
    end else if (bwd) begin
      sort_wa = slot + 1'b1;
    end else begin
      sort_wa = slot - 1'b1;
    end
  end
  assign sort_wd = (cmd.cmp_step && swap) ? cand : carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      bwd  <= 1'b0;
    end else begin
      case (cmd.slot_op)
        SLOT_CLEAR: begin
          slot <= '0;
          bwd  <= 1'b0;
        end
        SLOT_STEP:  slot <= bwd ? slot - 1'b1 : slot + 1'b1;
        SLOT_TURN: begin
          slot <= last_slot - 1'b1;
          bwd  <= 1'b1;
        end
        default:    slot <= slot;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand <= ord_val;
    end
    if (cmd.take || (cmd.cmp_step && !swap)) begin
      carry      <= cand;
      carry_dist <= acc;
    end
  end

  // Squared distance: one axis difference, one square and one accumulate per cycle.
  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        eye_sel = eye_x;
        pos_sel = pos_x;
      end
      AXIS_Y: begin
        eye_sel = eye_y;
        pos_sel = pos_y;
      end
      AXIS_Z: begin
        eye_sel = eye_z;
        pos_sel = pos_z;
      end
      default: begin
        eye_sel = eye_x;
        pos_sel = pos_x;
      end
    endcase
  end

  assign diff = {eye_sel[COORD_BITS-1], eye_sel} - {pos_sel[COORD_BITS-1], pos_sel};
  assign mag  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      abs_q <= mag[COORD_BITS-1:0];
    end
    if (cmd.sq_en) begin
      sq_q <= abs_q * abs_q;
    end
    if (cmd.acc_load) begin
      acc <= {2'b00, sq_q};
    end else if (cmd.acc_add) begin
      acc <= acc + {2'b00, sq_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      res <= '0;
    end else if (cmd.res_load) begin
      res <= IDX_W'(ord_val);
    end
    if (cmd.out_load) begin
      order_entry <= res;
    end
  end

endmodule

/* design/depth_order_shaker_pass.sv */
// Depth order shaker pass: one item at a time, one result beat per item.
// Write, read and unused commands finish without a sweep; a pass with
// n = min(object_count, 64) >= 2 sweeps forward and back, each slot visit stepping
// through the order store read, position read and the shared squaring unit.
// A new item is taken once the previous result sits in the output register.
// Synchronous reset: configuration to 0, order store to identity through valid bits.
module depth_order_shaker_pass import dosp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  dosp_in_if.sink              item,
  dosp_out_if.source           result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dosp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_cmd   (item.cmd),
    .item_ready (item.ready),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .status     (status),
    .cmd        (cmd)
  );

  dosp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_index  (item.index),
    .item_pos_x  (item.pos_x),
    .item_pos_y  (item.pos_y),
    .item_pos_z  (item.pos_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .order_entry (result.order_entry)
  );

endmodule

/* design/dosp_checker.sv */
// Port-level checks for the depth order shaker pass, bound to the top level.
module dosp_checker import dosp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] order_entry
);

  // Only one item is in flight, so ready drops right after an accepted beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was still in flight");

  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle and empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(order_entry))
    else $error("stalled result beat changed");

endmodule

bind depth_order_shaker_pass dosp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .order_entry (result.order_entry)
);

/* verif/tb.sv */
// Testbench for depth_order_shaker_pass: directed and random command streams checked by a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dosp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dosp_in_if in_ch ();
  dosp_out_if out_ch ();

  depth_order_shaker_pass dut (
    .clk       (clk),
    .rst       (rst),
    .item      (in_ch),
    .result    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted copy of the block's state and registers.
  logic [POS_W-1:0] obj_x [MAX_OBJECTS];
  logic [POS_W-1:0] obj_y [MAX_OBJECTS];
  logic [POS_W-1:0] obj_z [MAX_OBJECTS];
  logic             obj_written [MAX_OBJECTS];
  logic [IDX_W-1:0] depth_order [MAX_OBJECTS];
  logic [6:0]       count_reg;
  logic [POS_W-1:0] eye_x_reg;
  logic [POS_W-1:0] eye_y_reg;
  logic [POS_W-1:0] eye_z_reg;

  logic [IDX_W-1:0] pending_entries [$];
  logic [IDX_W-1:0] want_entry;
  int               fail_count = 0;
  logic             quiet = 1'b0;
  int               hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic int active_slots();
    return (count_reg > 7'd64) ? MAX_OBJECTS : int'(count_reg);
  endfunction

  function automatic longint range_sq(logic [IDX_W-1:0] obj);
    longint dx, dy, dz;
    dx = longint'($signed(eye_x_reg)) - longint'($signed(obj_x[obj]));
    dy = longint'($signed(eye_y_reg)) - longint'($signed(obj_y[obj]));
    dz = longint'($signed(eye_z_reg)) - longint'($signed(obj_z[obj]));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Neighbors trade places only when the left one is strictly farther.
  function automatic void order_compare(int right);
    logic [IDX_W-1:0] a, b;
    a = depth_order[right-1];
    b = depth_order[right];
    if (range_sq(a) > range_sq(b)) begin
      depth_order[right-1] = b;
      depth_order[right] = a;
    end
  endfunction

  function automatic void shake_order();
    int n, i;
    n = active_slots();
    if (n >= 2) begin
      for (i = 1; i < n; i++) order_compare(i);
      for (i = n - 1; i > 0; i--) order_compare(i);
    end
  endfunction

  function automatic logic [IDX_W-1:0] predict_entry(logic [CMD_W-1:0] op,
      logic [IDX_W-1:0] idx, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
      logic [POS_W-1:0] pz);
    logic [IDX_W-1:0] entry;
    entry = '0;
    case (op)
      CMD_WRITE: begin
        obj_x[idx] = px;
        obj_y[idx] = py;
        obj_z[idx] = pz;
        obj_written[idx] = 1'b1;
      end
      CMD_PASS: shake_order();
      CMD_READ: entry = depth_order[idx];
      default: ;
    endcase
    return entry;
  endfunction

  function automatic logic [POS_W-1:0] random_coord(logic [POS_W-1:0] center);
    int mode;
    mode = $urandom_range(9);
    if (mode < 5) return POS_W'($urandom);
    else if (mode < 8) return center + POS_W'($urandom_range(128)) - 16'd64;
    else if (mode == 8) return 16'h7FFF;
    else return 16'h8000;
  endfunction

  function automatic logic [POS_W-1:0] random_eye();
    int mode;
    mode = $urandom_range(9);
    if (mode < 8) return POS_W'($urandom);
    else if (mode == 8) return 16'h7FFF;
    else return 16'h8000;
  endfunction

  // The previous beat leaves valid high; the next call either reuses it or lowers it.
  task automatic send_item(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
      logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.index <= idx;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    pending_entries.insert(pending_entries.size(), predict_entry(op, idx, px, py, pz));
  endtask

  task automatic send_read(logic [IDX_W-1:0] slot);
    send_item(CMD_READ, slot, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_random_write(logic [IDX_W-1:0] idx);
    int src;
    src = $urandom_range(MAX_OBJECTS - 1);
    // Copying another object's position makes equal distances common.
    if ($urandom_range(9) >= 8 && obj_written[src])
      send_item(CMD_WRITE, idx, obj_x[src], obj_y[src], obj_z[src]);
    else
      send_item(CMD_WRITE, idx, random_coord(eye_x_reg), random_coord(eye_y_reg),
                random_coord(eye_z_reg));
  endtask

  // Every object that a pass can compare gets a position first.
  task automatic send_pass();
    int n, s;
    n = active_slots();
    if (n >= 2) begin
      for (s = 0; s < n; s++)
        if (!obj_written[depth_order[s]]) send_random_write(depth_order[s]);
    end
    send_item(CMD_PASS, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              POS_W'($urandom));
  endtask

  task automatic drain_items();
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
    drain_items();
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    case (which)
      CFG_OBJECT_COUNT: count_reg = value[6:0];
      CFG_EYE_X:        eye_x_reg = value;
      CFG_EYE_Y:        eye_y_reg = value;
      CFG_EYE_Z:        eye_z_reg = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_eye(logic [POS_W-1:0] ex, logic [POS_W-1:0] ey,
      logic [POS_W-1:0] ez);
    write_reg(CFG_EYE_X, ex);
    write_reg(CFG_EYE_Y, ey);
    write_reg(CFG_EYE_Z, ez);
  endtask

  task automatic send_random_item();
    int n, r;
    logic [IDX_W-1:0] idx;
    n = active_slots();
    r = $urandom_range(99);
    if (r < 40) begin
      if (n > 0 && $urandom_range(4) != 0) idx = IDX_W'($urandom_range(n - 1));
      else idx = IDX_W'($urandom);
      send_random_write(idx);
    end else if (r < 60) begin
      send_pass();
    end else if (r < 95) begin
      if (n > 0 && $urandom_range(9) < 7) idx = IDX_W'($urandom_range(n - 1));
      else idx = IDX_W'($urandom);
      send_read(idx);
    end else begin
      send_item(CMD_UNUSED, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                POS_W'($urandom));
    end
  endtask

  // Identity order after reset, passes that change nothing, the unused command.
  task automatic test_after_reset();
    send_read(6'd0);
    send_read(6'd63);
    send_read(6'd42);
    send_read(6'd21);
    send_pass();
    send_read(6'd1);
    send_item(CMD_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_OBJECT_COUNT, 16'd1);
    send_pass();
    send_read(6'd0);
  endtask

  // Farthest object at the far corner, two objects tied at the eye.
  task automatic test_directed_order();
    write_reg(CFG_OBJECT_COUNT, 16'd3);
    write_eye(16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(CMD_WRITE, 6'd0, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(CMD_WRITE, 6'd1, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(CMD_WRITE, 6'd2, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_pass();
    send_read(6'd0);
    send_read(6'd1);
    send_read(6'd2);
    write_reg(CFG_OBJECT_COUNT, 16'd2);
    send_pass();
    send_read(6'd0);
    send_item(CMD_WRITE, 6'd1, 16'h0000, 16'h0000, 16'h0000);
    send_pass();
    send_read(6'd0);
    send_read(6'd1);
  endtask

  task automatic test_random_mix(int phases, int items);
    int p, k, r, n;
    for (p = 0; p < phases; p++) begin
      r = $urandom_range(99);
      if (r < 10) n = $urandom_range(1);
      else if (r < 85) n = $urandom_range(10, 2);
      else n = $urandom_range(24, 11);
      write_reg(CFG_OBJECT_COUNT, CFG_W'(n));
      write_eye(random_eye(), random_eye(), random_eye());
      quiet <= (p == 3);
      for (k = 0; k < items; k++) send_random_item();
    end
    drain_items();
    quiet <= 1'b0;
  endtask

  // Whole store in play, including counts that saturate at capacity.
  task automatic test_full_capacity();
    int s;
    write_reg(CFG_OBJECT_COUNT, 16'd64);
    write_eye(16'h8000, 16'h8000, 16'h8000);
    send_pass();
    for (s = 0; s < MAX_OBJECTS; s++) send_read(IDX_W'(s));
    write_reg(CFG_OBJECT_COUNT, 16'd127);
    write_eye(random_eye(), random_eye(), random_eye());
    repeat (2) send_pass();
    for (s = 0; s < MAX_OBJECTS; s++) send_read(IDX_W'(s));
    write_reg(CFG_OBJECT_COUNT, 16'd100);
    write_eye(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pass();
    repeat (16) send_read(IDX_W'($urandom));
  endtask

  // The receiver holds off while beats keep coming, so the input stalls.
  task automatic test_output_stall();
    write_reg(CFG_OBJECT_COUNT, 16'd6);
    quiet <= 1'b1;
    hold_request <= HOLD_CYCLES;
    repeat (16) send_random_item();
    drain_items();
    quiet <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request <= 0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_entries.size() == 0) begin
        note_failure($sformatf("result beat with nothing pending, order_entry %0d",
                               out_ch.order_entry));
      end else begin
        want_entry = pending_entries.pop_front();
        if (out_ch.order_entry !== want_entry)
          note_failure($sformatf("order_entry mismatch: expected %0d, got %0d",
                                 want_entry, out_ch.order_entry));
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_WRITE;
    in_ch.index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OBJECT_COUNT;
    cfg_data  = '0;
    count_reg = '0;
    eye_x_reg = '0;
    eye_y_reg = '0;
    eye_z_reg = '0;
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      obj_x[i] = '0;
      obj_y[i] = '0;
      obj_z[i] = '0;
      obj_written[i] = 1'b0;
      depth_order[i] = IDX_W'(i);
    end
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_directed_order();
    test_random_mix(10, 180);
    test_output_stall();
    test_full_capacity();

    drain_items();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_entries.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_entries.size()));
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
